/* rtl/atf_pkg.sv */
// ----------------------------------------------------------------------------
// atf_pkg
// Types and character constants for the AT response line framer.
// ----------------------------------------------------------------------------
package atf_pkg;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_GT = 8'h3E;

   typedef enum logic [2:0] {
      ST_IDLE      = 3'd0,
      ST_IDLE_CR   = 3'd1,
      ST_IDLE_LF   = 3'd2,
      ST_RESULT    = 3'd3,
      ST_RESULT_CR = 3'd4,
      ST_RESULT_LF = 3'd5,
      ST_PROMPT    = 3'd6,
      ST_RAWDATA   = 3'd7
   } parse_state_type;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_LINE    = 2'd1,
      KIND_PAYLOAD = 2'd2
   } byte_kind_type;

   typedef enum logic [1:0] {
      LEND_NONE     = 2'd0,
      LEND_CR       = 2'd1,
      LEND_OVERFLOW = 2'd2
   } line_end_type;

   typedef struct packed {
      parse_state_type parse_state;
      logic [7:0]      line_count;
      logic [11:0]     payload_count;
      logic [11:0]     payload_expected;
   } framer_state_type;

   typedef struct packed {
      logic        mode;
      logic [7:0]  rx_byte;
      logic [11:0] raw_length;
   } req_item_type;

   typedef struct packed {
      byte_kind_type byte_kind;
      logic [7:0]    out_byte;
      line_end_type  line_end;
      logic [7:0]    line_length;
      logic          payload_end;
      logic [11:0]   payload_length;
      logic          prompt_seen;
   } rsp_item_type;

endpackage

/* rtl/atf_step.sv */
// ----------------------------------------------------------------------------
// atf_step
// One parser step: next framer state and the result for one input item.
// ----------------------------------------------------------------------------
module atf_step #(
   parameter int unsigned LINE_MAX    = 128,
   parameter int unsigned PAYLOAD_MAX = 2048
) (
   input  atf_pkg::framer_state_type cur_state,
   input  atf_pkg::req_item_type     item,
   output atf_pkg::framer_state_type nxt_state,
   output atf_pkg::rsp_item_type     result
);

   localparam logic [7:0]  LineMax    = 8'(LINE_MAX);
   localparam logic [11:0] PayloadMax = 12'(PAYLOAD_MAX);

   always_comb begin
      atf_pkg::framer_state_type nxt;
      atf_pkg::byte_kind_type    kind;
      atf_pkg::line_end_type     lend;
      logic [7:0]                llen;
      logic                      pend;
      logic [11:0]               plen;
      logic                      line_done;
      logic                      new_line;
      logic [7:0]                b;

      nxt       = cur_state;
      kind      = atf_pkg::KIND_NONE;
      lend      = atf_pkg::LEND_NONE;
      llen      = '0;
      pend      = 1'b0;
      plen      = '0;
      line_done = 1'b0;
      new_line  = 1'b0;
      b         = item.rx_byte;

      if (item.mode) begin
         nxt.payload_expected = (item.raw_length > PayloadMax) ? PayloadMax : item.raw_length;
         nxt.payload_count    = '0;
      end else begin
         unique case (cur_state.parse_state)
            atf_pkg::ST_IDLE_CR: begin
               if (b == atf_pkg::CH_LF) nxt.parse_state = atf_pkg::ST_RESULT_LF;
               else if (b == atf_pkg::CH_CR) nxt.parse_state = atf_pkg::ST_IDLE_CR;
               else new_line = 1'b1;
            end
            atf_pkg::ST_RESULT_CR: begin
               nxt.line_count = '0;
               if (b == atf_pkg::CH_LF) begin
                  nxt.parse_state = (cur_state.payload_expected != '0) ?
                                    atf_pkg::ST_RESULT_LF : atf_pkg::ST_IDLE;
               end else begin
                  line_done = 1'b1;
               end
            end
            atf_pkg::ST_RESULT_LF: begin
               nxt.line_count = '0;
               if (cur_state.payload_expected != '0) begin
                  nxt.payload_count = 12'd1;
                  nxt.parse_state   = atf_pkg::ST_RAWDATA;
                  kind              = atf_pkg::KIND_PAYLOAD;
               end else begin
                  line_done = 1'b1;
               end
            end
            atf_pkg::ST_RESULT: begin
               if (b == atf_pkg::CH_CR) begin
                  nxt.parse_state = atf_pkg::ST_RESULT_CR;
               end else begin
                  nxt.line_count = cur_state.line_count + 8'd1;
                  kind           = atf_pkg::KIND_LINE;
               end
            end
            atf_pkg::ST_RAWDATA: begin
               if (cur_state.payload_count >= cur_state.payload_expected) begin
                  nxt.line_count = '0;
                  line_done      = 1'b1;
               end else begin
                  nxt.payload_count = cur_state.payload_count + 12'd1;
                  kind              = atf_pkg::KIND_PAYLOAD;
               end
            end
            atf_pkg::ST_PROMPT: begin
               nxt.line_count = '0;
               if (b == atf_pkg::CH_CR) nxt.parse_state = atf_pkg::ST_IDLE_CR;
               else new_line = 1'b1;
            end
            atf_pkg::ST_IDLE, atf_pkg::ST_IDLE_LF: begin
               if (b == atf_pkg::CH_CR) nxt.parse_state = atf_pkg::ST_IDLE_CR;
               else if (b == atf_pkg::CH_GT) nxt.parse_state = atf_pkg::ST_PROMPT;
               else if (b == atf_pkg::CH_LF) nxt.parse_state = atf_pkg::ST_RESULT_LF;
               else new_line = 1'b1;
            end
         endcase

         // after a finished line: CR, prompt or first byte of a new line
         if (line_done) begin
            if (b == atf_pkg::CH_CR) nxt.parse_state = atf_pkg::ST_IDLE_CR;
            else if (b == atf_pkg::CH_GT) nxt.parse_state = atf_pkg::ST_PROMPT;
            else new_line = 1'b1;
         end

         if (new_line) begin
            nxt.parse_state = atf_pkg::ST_RESULT;
            nxt.line_count  = 8'd1;
            kind            = atf_pkg::KIND_LINE;
         end

         if (nxt.line_count >= LineMax) begin
            lend            = atf_pkg::LEND_OVERFLOW;
            llen            = nxt.line_count;
            nxt.line_count  = '0;
            nxt.parse_state = atf_pkg::ST_IDLE;
         end
         if (nxt.parse_state == atf_pkg::ST_RESULT_CR && nxt.line_count != '0) begin
            lend = atf_pkg::LEND_CR;
            llen = nxt.line_count;
         end
         if (nxt.parse_state == atf_pkg::ST_RAWDATA &&
             nxt.payload_count >= nxt.payload_expected) begin
            pend                 = 1'b1;
            plen                 = nxt.payload_count;
            nxt.line_count       = '0;
            nxt.parse_state      = atf_pkg::ST_IDLE;
            nxt.payload_expected = '0;
         end
      end

      nxt_state             = nxt;
      result.byte_kind      = kind;
      result.out_byte       = (kind != atf_pkg::KIND_NONE) ? b : 8'd0;
      result.line_end       = lend;
      result.line_length    = llen;
      result.payload_end    = pend;
      result.payload_length = plen;
      result.prompt_seen    = (nxt.parse_state == atf_pkg::ST_PROMPT);
   end

endmodule

/* rtl/at_response_line_framer.sv */
// ----------------------------------------------------------------------------
// at_response_line_framer
// An input item is parsed as it moves from the input register into the result
// register; the parser state updates in that same move.
// Throughput: one byte per cycle unless the result register is held by a low
// rsp_tready.
// Reset (synchronous): parser idle, counters cleared, both stages emptied.
// ----------------------------------------------------------------------------
module at_response_line_framer #(
   parameter int unsigned LINE_MAX    = 128,
   parameter int unsigned PAYLOAD_MAX = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // rx_byte[7:0], raw_length[19:8], zero pad
   input  logic [0:0]  req_tuser,   // mode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_byte[7:0], line_end[9:8],
                                    // line_length[17:10], payload_length[29:18],
                                    // prompt_seen[30], zero pad
   output logic [1:0]  rsp_tuser,   // byte_kind[1:0]
   output logic        rsp_tlast    // payload_end
);

   logic                      in_valid_ff;
   atf_pkg::req_item_type     in_item_ff;
   atf_pkg::framer_state_type state_ff;
   atf_pkg::framer_state_type state_in;
   logic                      rsp_valid_ff;
   atf_pkg::rsp_item_type     rsp_ff;
   atf_pkg::rsp_item_type     rsp_in;
   logic                      advance;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   atf_step #(
      .LINE_MAX    (LINE_MAX),
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_step (
      .cur_state (state_ff),
      .item      (in_item_ff),
      .nxt_state (state_in),
      .result    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{parse_state: atf_pkg::ST_IDLE, line_count: '0,
                           payload_count: '0, payload_expected: '0};
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.mode       <= req_tuser[0];
         in_item_ff.rx_byte    <= req_tdata[7:0];
         in_item_ff.raw_length <= req_tdata[19:8];
      end
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.byte_kind;
   assign rsp_tlast  = rsp_ff.payload_end;
   assign rsp_tdata  = {1'b0, rsp_ff.prompt_seen, rsp_ff.payload_length,
                        rsp_ff.line_length, rsp_ff.line_end, rsp_ff.out_byte};

endmodule
